[rtl/box_blur_3x3_rgb_macros.svh]
// Assertion macros for the 3x3 box blur checker.
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

// Checked only while the block is out of reset.
`define BB3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BB3_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bb3_pkg.sv]
package bb3_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LK, ST_LN, ST_LH, ST_W1, ST_W2, ST_RT, ST_RM,
    ST_RB, ST_P0, ST_P1, ST_P2, ST_SHIFT, ST_SUM, ST_DIV, ST_OUT
  } state_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic MODE_PIXEL = 1'b0;

  localparam int ROW_W     = 16;
  localparam int PIX_W     = 24;
  localparam int SUM_W     = 12;
  localparam int CNT_W     = 4;
  localparam int NUM_W     = 13;
  localparam int DEN_W     = 5;
  localparam int RCP_W     = 16;
  localparam int RCP_SHIFT = 16;

  // floor(2^16 / (2 * count)) for the rounded mean.
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] r;
    unique case (cnt)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10922;
      4'd4:    r = 16'd8192;
      4'd5:    r = 16'd6553;
      4'd6:    r = 16'd5461;
      4'd7:    r = 16'd4681;
      4'd8:    r = 16'd4096;
      4'd9:    r = 16'd3640;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/bb3_line_mem.sv]
module bb3_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                     clk,
  input  bb3_pkg::mem_cmd_t        cmd,
  input  logic [AW-1:0]            addr,
  input  logic [bb3_pkg::PIX_W-1:0] wdata,
  output logic [bb3_pkg::PIX_W-1:0] rdata
);

  logic [bb3_pkg::PIX_W-1:0] line_r [DEPTH];
  logic [bb3_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.we) begin
        line_r[addr] <= wdata;
      end else begin
        rdata_r <= line_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/bb3_index.sv]
module bb3_index #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic [bb3_pkg::ROW_W-1:0]            row_in,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       mul_in,
  input  logic [18+$clog2(MAX_WIDTH+1)-1:0]    ofs_in,
  output logic [18+$clog2(MAX_WIDTH+1)-1:0]    lin,
  output logic [$clog2(2*MAX_WIDTH)-1:0]       idx
);

  localparam int RING = 2 * MAX_WIDTH;
  localparam int AW   = $clog2(RING);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int NB   = 18 + WW;
  localparam int PW   = bb3_pkg::ROW_W + WW;
  localparam int MW   = NB - AW + 1;
  localparam logic [MW-1:0] RCP = MW'((64'd1 << NB) / 64'(RING));

  logic [PW-1:0]    prod;
  logic [NB-1:0]    lin_r;
  logic [NB-1:0]    lin2_r;
  logic [NB+MW-1:0] p2;
  logic [MW-1:0]    q_r;
  logic [NB-1:0]    qm;
  logic [NB-1:0]    rem;
  logic [NB-1:0]    rem_c;
  logic [AW-1:0]    idx_r;

  assign prod = PW'(row_in) * PW'(mul_in);
  // Quotient estimate is exact or one short, so one subtract corrects it.
  assign p2    = (NB+MW)'(lin_r) * (NB+MW)'(RCP);
  assign qm    = NB'(NB'(q_r) * NB'(RING));
  assign rem   = lin2_r - qm;
  assign rem_c = (rem >= NB'(RING)) ? rem - NB'(RING) : rem;

  always_ff @(posedge clk) begin
    lin_r  <= NB'(prod) + ofs_in;
    lin2_r <= lin_r;
    q_r    <= MW'(p2 >> NB);
    idx_r  <= AW'(rem_c);
  end

  assign lin = lin_r;
  assign idx = idx_r;

endmodule

[rtl/bb3_mean.sv]
module bb3_mean #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic [bb3_pkg::PIX_W-1:0]          win [9],
  input  logic [bb3_pkg::ROW_W-1:0]          row,
  input  logic [$clog2(MAX_WIDTH)-1:0]       col,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     w,
  input  logic [bb3_pkg::ROW_W-1:0]          h,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = CW + 2;
  localparam int RW = bb3_pkg::ROW_W + 1;

  logic [2:0]                      col_ok;
  logic [2:0]                      row_ok;
  logic [bb3_pkg::SUM_W-1:0]       sum_a [3];
  logic [bb3_pkg::CNT_W-1:0]       cnt_a;
  logic [bb3_pkg::SUM_W-1:0]       sum_r [3];
  logic [bb3_pkg::CNT_W-1:0]       cnt_r;
  logic [bb3_pkg::NUM_W-1:0]       num   [3];
  logic [bb3_pkg::NUM_W-1:0]       num_r [3];
  logic [bb3_pkg::NUM_W-1:0]       qa_r  [3];
  logic [bb3_pkg::DEN_W-1:0]       den_r;
  logic                            zero_r;
  logic [bb3_pkg::RCP_W-1:0]       rcp;
  logic [7:0]                      res   [3];

  assign col_ok[0] = (col != '0);
  assign col_ok[1] = XW'(col) < XW'(w);
  assign col_ok[2] = (XW'(col) + XW'(1)) < XW'(w);
  assign row_ok[0] = (row != '0);
  assign row_ok[1] = RW'(row) < RW'(h);
  assign row_ok[2] = (RW'(row) + RW'(1)) < RW'(h);

  always_comb begin
    sum_a[0] = '0;
    sum_a[1] = '0;
    sum_a[2] = '0;
    cnt_a    = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (col_ok[i] && row_ok[j]) begin
          sum_a[0] = sum_a[0] + bb3_pkg::SUM_W'(win[i*3+j][23:16]);
          sum_a[1] = sum_a[1] + bb3_pkg::SUM_W'(win[i*3+j][15:8]);
          sum_a[2] = sum_a[2] + bb3_pkg::SUM_W'(win[i*3+j][7:0]);
          cnt_a    = cnt_a + bb3_pkg::CNT_W'(1);
        end
      end
    end
  end

  assign rcp = bb3_pkg::recip(cnt_r);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = {sum_r[k], 1'b0} + bb3_pkg::NUM_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_a;
    cnt_r  <= cnt_a;
    den_r  <= {cnt_r, 1'b0};
    zero_r <= (cnt_r == '0);
    for (int k = 0; k < 3; k++) begin
      num_r[k] <= num[k];
      qa_r[k]  <= bb3_pkg::NUM_W'(((bb3_pkg::NUM_W + bb3_pkg::RCP_W)'(num[k]) *
                   (bb3_pkg::NUM_W + bb3_pkg::RCP_W)'(rcp)) >> bb3_pkg::RCP_SHIFT);
    end
  end

  // The estimate is at most one below the true quotient.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (zero_r) begin
        res[k] = '0;
      end else if ((num_r[k] - bb3_pkg::NUM_W'(qa_r[k] * bb3_pkg::NUM_W'(den_r))) >=
                   bb3_pkg::NUM_W'(den_r)) begin
        res[k] = 8'(qa_r[k] + bb3_pkg::NUM_W'(1));
      end else begin
        res[k] = 8'(qa_r[k]);
      end
    end
  end

  assign red   = res[0];
  assign green = res[1];
  assign blue  = res[2];

endmodule

[rtl/box_blur_3x3_rgb.sv]
// 3x3 box blur on an RGB raster stream, one word in at a time.
// A word is taken only in the idle state. A pixel that releases no output is done after the ring
// write; one that releases an output, or a drain word with an output left, runs on to the output
// register. The sequence is set by the single-port line memory (up to five accesses per word) and
// the shared index multiplier pipeline. Reset is synchronous; it clears counters and window, sets
// configuration to its defaults, and the line memory is not cleared (undefined until written).
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bb3_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bb3_pkg::out_word_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // The line memory is a ring of two rows. Its address for a linear pixel index is taken
  // modulo the ring size by the index unit, so a width change between frames needs nothing.
  localparam int RING = 2 * MAX_WIDTH;
  localparam int AW   = $clog2(RING);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int NB   = 18 + WW;
  localparam int XW   = CW + 2;
  localparam int RW   = bb3_pkg::ROW_W + 1;
  localparam int TW   = AW + 2;

  bb3_pkg::state_t state_r, state_nxt;

  logic [10:0]                 cfg_width_r;
  logic [bb3_pkg::ROW_W-1:0]   cfg_height_r;
  logic [WW-1:0]               w_eff;
  logic [bb3_pkg::ROW_W-1:0]   h_eff;

  // Stream position, as row and column of the next input and the next output.
  logic [CW-1:0]               in_col_r;
  logic [bb3_pkg::ROW_W-1:0]   in_row_r;
  logic [CW-1:0]               out_col_r;
  logic [bb3_pkg::ROW_W-1:0]   out_row_r;

  logic                        pix_r;
  logic                        fire_r;
  logic                        first_r;
  logic [NB-1:0]               k_r;
  logic [NB-1:0]               n_r;
  logic [AW-1:0]               ring_a_r;
  logic [AW-1:0]               top_a_r;
  logic [AW-1:0]               mid_a_r;
  logic [bb3_pkg::ROW_W-1:0]   em_row_r;
  logic [CW-1:0]               em_col_r;
  logic [bb3_pkg::PIX_W-1:0]   px_r;
  logic [bb3_pkg::PIX_W-1:0]   top_r;
  logic [bb3_pkg::PIX_W-1:0]   mid_r;
  logic [bb3_pkg::PIX_W-1:0]   bot_r;
  logic [bb3_pkg::PIX_W-1:0]   pre7_r;
  logic [bb3_pkg::PIX_W-1:0]   pre8_r;
  logic [bb3_pkg::PIX_W-1:0]   win_r [9];
  logic                        frame_end_r;
  logic                        out_valid_r;
  bb3_pkg::out_word_t          out_data_r;

  logic [bb3_pkg::ROW_W-1:0]   ix_row;
  logic [NB-1:0]               ix_ofs;
  logic [NB-1:0]               ix_lin;
  logic [AW-1:0]               ix_idx;

  bb3_pkg::mem_cmd_t           mem_cmd;
  logic [AW-1:0]               mem_addr;
  logic [bb3_pkg::PIX_W-1:0]   mem_rd;

  logic [TW-1:0]               t_top;
  logic [TW-1:0]               t_mid;
  logic                        in_wrap;
  logic                        end_col;
  logic                        end_row;
  logic                        load_out;
  logic [7:0]                  m_red;
  logic [7:0]                  m_green;
  logic [7:0]                  m_blue;

  // Out-of-range widths and a zero height are folded to the nearest legal value.
  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_r);
    end
  end

  assign h_eff = (cfg_height_r == '0) ? bb3_pkg::ROW_W'(1) : cfg_height_r;

  // Ring addresses of the pixel one row and two rows above, wrapped back into the ring.
  assign t_top = TW'(ix_idx) + TW'(RING) - (TW'(w_eff) << 1);
  assign t_mid = TW'(ix_idx) + TW'(RING) - TW'(w_eff);

  assign in_wrap  = (XW'(in_col_r) + XW'(1)) >= XW'(w_eff);
  assign end_col  = (XW'(em_col_r) + XW'(1)) >= XW'(w_eff);
  assign end_row  = (RW'(em_row_r) + RW'(1)) >= RW'(h_eff);
  assign load_out = (state_r == bb3_pkg::ST_OUT) && (!out_valid_r || !out_stall);

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bb3_index #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_index (
    .clk    (clk),
    .row_in (ix_row),
    .mul_in (w_eff),
    .ofs_in (ix_ofs),
    .lin    (ix_lin),
    .idx    (ix_idx)
  );

  bb3_line_mem #(
    .DEPTH(RING),
    .AW   (AW)
  ) u_line_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (px_r),
    .rdata (mem_rd)
  );

  bb3_mean #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_mean (
    .clk   (clk),
    .win   (win_r),
    .row   (em_row_r),
    .col   (em_col_r),
    .w     (w_eff),
    .h     (h_eff),
    .red   (m_red),
    .green (m_green),
    .blue  (m_blue)
  );

  // Sequencer. The index unit is fed the output index, then the input index (or, for a
  // drain word, the index of the pixel that completes the window), then the frame size.
  // Each linear index shows up in the cycle after it is fed, and its ring address follows it
  // through the index unit's remainder registers. The frame size is fed in both ST_LH and ST_W1
  // so it is still at the index output when the drain check looks at it.
  // Memory accesses follow one per cycle: row above twice, row above once, then the
  // current pixel is written (or read back when draining). The first output of a frame
  // also reloads the centre and bottom cells of the middle window column from the ring.
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    ix_row    = '0;
    ix_ofs    = '0;
    mem_cmd   = '0;
    mem_addr  = '0;
    unique case (state_r)
      bb3_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (in_data.mode == bb3_pkg::MODE_PIXEL || in_row_r >= h_eff)) begin
          state_nxt = bb3_pkg::ST_LK;
        end
      end
      bb3_pkg::ST_LK: begin
        ix_row    = out_row_r;
        ix_ofs    = NB'(out_col_r);
        state_nxt = bb3_pkg::ST_LN;
      end
      bb3_pkg::ST_LN: begin
        if (pix_r) begin
          ix_row = in_row_r;
          ix_ofs = NB'(in_col_r);
        end else begin
          ix_row = out_row_r;
          ix_ofs = NB'(out_col_r) + NB'(w_eff) + NB'(1);
        end
        state_nxt = bb3_pkg::ST_LH;
      end
      bb3_pkg::ST_LH: begin
        ix_row    = h_eff;
        state_nxt = bb3_pkg::ST_W1;
      end
      bb3_pkg::ST_W1: begin
        ix_row    = h_eff;
        state_nxt = bb3_pkg::ST_W2;
      end
      bb3_pkg::ST_W2: begin
        // A drain word with nothing left to release only resets the position.
        if (!pix_r && k_r >= ix_lin) begin
          state_nxt = bb3_pkg::ST_IDLE;
        end else begin
          state_nxt = bb3_pkg::ST_RT;
        end
      end
      bb3_pkg::ST_RT: begin
        mem_cmd.en = 1'b1;
        mem_addr   = top_a_r;
        state_nxt  = bb3_pkg::ST_RM;
      end
      bb3_pkg::ST_RM: begin
        mem_cmd.en = 1'b1;
        mem_addr   = mid_a_r;
        state_nxt  = bb3_pkg::ST_RB;
      end
      bb3_pkg::ST_RB: begin
        mem_cmd.en = 1'b1;
        mem_cmd.we = pix_r;
        mem_addr   = ring_a_r;
        if (pix_r && !fire_r) begin
          state_nxt = bb3_pkg::ST_IDLE;
        end else begin
          state_nxt = bb3_pkg::ST_P0;
        end
      end
      bb3_pkg::ST_P0: begin
        mem_cmd.en = 1'b1;
        mem_addr   = '0;
        state_nxt  = bb3_pkg::ST_P1;
      end
      bb3_pkg::ST_P1: begin
        mem_cmd.en = 1'b1;
        mem_addr   = AW'(w_eff);
        state_nxt  = bb3_pkg::ST_P2;
      end
      bb3_pkg::ST_P2: begin
        state_nxt = bb3_pkg::ST_SHIFT;
      end
      bb3_pkg::ST_SHIFT: begin
        state_nxt = bb3_pkg::ST_SUM;
      end
      bb3_pkg::ST_SUM: begin
        state_nxt = bb3_pkg::ST_DIV;
      end
      bb3_pkg::ST_DIV: begin
        state_nxt = bb3_pkg::ST_OUT;
      end
      bb3_pkg::ST_OUT: begin
        if (load_out) begin
          state_nxt = bb3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bb3_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state: sequencer, configuration, stream position, window and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bb3_pkg::ST_IDLE;
      cfg_width_r  <= 11'd1024;
      cfg_height_r <= 16'd1;
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      pix_r        <= 1'b0;
      fire_r       <= 1'b0;
      first_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        if (cfg_index == bb3_pkg::REG_FRAME_WIDTH) begin
          cfg_width_r <= cfg_data[10:0];
        end else if (cfg_index == bb3_pkg::REG_FRAME_HEIGHT) begin
          cfg_height_r <= cfg_data;
        end
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        bb3_pkg::ST_IDLE: begin
          if (in_valid) begin
            pix_r <= (in_data.mode == bb3_pkg::MODE_PIXEL) && (in_row_r < h_eff);
          end
        end
        bb3_pkg::ST_W2: begin
          fire_r  <= (n_r == k_r + NB'(w_eff) + NB'(1));
          first_r <= (out_row_r == '0) && (out_col_r == '0);
          if (!pix_r && k_r >= ix_lin) begin
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_col_r <= '0;
            out_row_r <= '0;
          end
        end
        bb3_pkg::ST_RB: begin
          if (pix_r) begin
            if (in_wrap) begin
              in_col_r <= '0;
              in_row_r <= in_row_r + bb3_pkg::ROW_W'(1);
            end else begin
              in_col_r <= in_col_r + CW'(1);
            end
          end
        end
        bb3_pkg::ST_SHIFT: begin
          // The window moves one column right; the first output of a frame fills the middle column
          // with zero on top and the ring's first pixels of rows zero and one below it.
          win_r[0] <= win_r[3];
          win_r[1] <= win_r[4];
          win_r[2] <= win_r[5];
          win_r[3] <= first_r ? '0 : win_r[6];
          win_r[4] <= first_r ? pre7_r : win_r[7];
          win_r[5] <= first_r ? pre8_r : win_r[8];
          win_r[6] <= top_r;
          win_r[7] <= mid_r;
          win_r[8] <= bot_r;
          if (end_row && end_col) begin
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_col_r <= '0;
            out_row_r <= '0;
          end else if (end_col) begin
            out_col_r <= '0;
            out_row_r <= em_row_r + bb3_pkg::ROW_W'(1);
          end else begin
            out_col_r <= em_col_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Data path registers; these need no reset.
  always_ff @(posedge clk) begin
    if (state_r == bb3_pkg::ST_IDLE && in_valid) begin
      px_r <= {in_data.red_in, in_data.green_in, in_data.blue_in};
    end
    if (state_r == bb3_pkg::ST_LN) begin
      k_r <= ix_lin;
    end
    if (state_r == bb3_pkg::ST_LH) begin
      n_r <= ix_lin;
    end
    if (state_r == bb3_pkg::ST_W2) begin
      ring_a_r <= ix_idx;
      top_a_r  <= (t_top >= TW'(RING)) ? AW'(t_top - TW'(RING)) : AW'(t_top);
      mid_a_r  <= (t_mid >= TW'(RING)) ? AW'(t_mid - TW'(RING)) : AW'(t_mid);
      em_row_r <= out_row_r;
      em_col_r <= out_col_r;
    end
    if (state_r == bb3_pkg::ST_RM) begin
      top_r <= mem_rd;
    end
    if (state_r == bb3_pkg::ST_RB) begin
      mid_r <= mem_rd;
      if (pix_r) begin
        bot_r <= px_r;
      end
    end
    if (state_r == bb3_pkg::ST_P0 && !pix_r) begin
      bot_r <= mem_rd;
    end
    if (state_r == bb3_pkg::ST_P1) begin
      pre7_r <= mem_rd;
    end
    if (state_r == bb3_pkg::ST_P2) begin
      pre8_r <= mem_rd;
    end
    if (state_r == bb3_pkg::ST_SHIFT) begin
      frame_end_r <= end_row && end_col;
    end
    if (load_out) begin
      out_data_r.red_out   <= m_red;
      out_data_r.green_out <= m_green;
      out_data_r.blue_out  <= m_blue;
      out_data_r.frame_end <= frame_end_r;
    end
  end

endmodule

[rtl/bb3_chk.sv]
`include "box_blur_3x3_rgb_macros.svh"

module bb3_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bb3_pkg::out_word_t out_data
);

  // A held result word keeps its value until it is taken.
  `BB3_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result word changed while stalled")

  // A result is never loaded in the cycle right after a word is taken in.
  `BB3_ASSERT(a_no_early_out, in_valid && !in_stall |=> !$rose(out_valid), "result appeared right after an input word")

  // Reset empties the output register.
  `BB3_ASSERT_ANY(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind box_blur_3x3_rgb bb3_chk u_bb3_chk (.*);
